### design/base32_seven_bit_codec_assert.svh
// ----------------------------------------------------------------------------
// base32 seven-bit codec assertion macros
// concurrent checks clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef BASE32_SEVEN_BIT_CODEC_ASSERT_SVH
`define BASE32_SEVEN_BIT_CODEC_ASSERT_SVH

`ifndef SYNTH
// plain property that must hold at every clock edge out of reset
`define B32S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// antecedent implies consequent in the following cycle
`define B32S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B32S_ASSERT(lbl, prop, msg)
`define B32S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/b32s_pkg.sv
// ----------------------------------------------------------------------------
// b32s_pkg
// shared types and constants of the base32 seven-bit codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b32s_pkg;

    localparam int GROUP_W = 35;

    // register word index on the configuration port
    localparam logic REG_MODE = 1'b0;

    // mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // one packed group handed from front to back
    typedef struct packed {
        logic [GROUP_W-1:0] bits;      // msb-aligned, zero padded
        logic               msg_end;   // group closed by the last beat of a message
    } group_t;

    // queue status towards the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### design/b32s_front.sv
// ----------------------------------------------------------------------------
// b32s_front
// accepts input beats and packs them into msb-aligned 35-bit groups
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32s_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              mode,
    input  wire logic              clear,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_last,
    input  wire logic              q_full,
    output logic                   push,
    output b32s_pkg::group_t       push_grp
);
    import b32s_pkg::*;

    logic [GROUP_W-1:0] acc_reg, acc_next;
    logic [2:0]         count_reg, count_next;
    logic [6:0]         item;
    logic [5:0]         shamt;
    logic [GROUP_W-1:0] acc_merged;
    logic               accept;
    logic               done;

    // item value: 7-bit byte, or symbol decoded from its character
    always_comb begin
        if (mode == MODE_DECODE) begin
            if (in_char >= 8'd97) begin
                item = {2'b00, 5'(in_char - 8'd97)};
            end else begin
                item = {2'b00, 5'(in_char - 8'd22)};
            end
        end else begin
            item = in_char[6:0];
        end
    end

    // bit position of this item within the group
    always_comb begin
        if (mode == MODE_DECODE) begin
            shamt = 6'd30 - (6'(count_reg) * 6'd5);
        end else begin
            shamt = 6'd28 - (6'(count_reg) * 6'd7);
        end
    end

    assign acc_merged = acc_reg | ({28'd0, item} << shamt);
    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign done       = in_last ||
                        (count_reg == ((mode == MODE_DECODE) ? 3'd6 : 3'd4));
    assign push       = accept && done;

    always_comb begin
        push_grp.bits    = acc_merged;
        push_grp.msg_end = in_last;
        acc_next         = acc_reg;
        count_next       = count_reg;
        if (clear) begin
            acc_next   = '0;
            count_next = '0;
        end else if (accept) begin
            if (done) begin
                acc_next   = '0;
                count_next = '0;
            end else begin
                acc_next   = acc_merged;
                count_next = 3'(count_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            count_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/b32s_queue.sv
// ----------------------------------------------------------------------------
// b32s_queue
// two-entry group queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32s_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire b32s_pkg::group_t  push_grp,
    input  wire logic              pop,
    output b32s_pkg::group_t       head,
    output b32s_pkg::queue_stat_t  stat
);
    import b32s_pkg::*;

    group_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.empty = (fill_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = 2'(fill_reg + 2'd1);
        end else if (do_pop && !do_push) begin
            fill_next = 2'(fill_reg - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

### design/b32s_back.sv
// ----------------------------------------------------------------------------
// b32s_back
// serialises one group into five bytes or seven symbol characters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32s_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              mode,
    input  wire b32s_pkg::group_t  head,
    input  wire b32s_pkg::queue_stat_t stat,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   out_last,
    output logic                   out_end
);
    import b32s_pkg::*;

    logic               busy_reg, busy_next;
    logic [GROUP_W-1:0] grp_reg, grp_next;
    logic [2:0]         idx_reg, idx_next;
    logic               end_reg, end_next;
    logic [4:0]         sym;
    logic               beat;

    assign sym       = grp_reg[GROUP_W-1 -: 5];
    assign out_valid = busy_reg;
    assign out_last  = (idx_reg == ((mode == MODE_DECODE) ? 3'd4 : 3'd6));
    assign out_end   = end_reg;
    assign beat      = out_valid && out_ready;
    assign pop       = (!busy_reg || (beat && out_last)) && !stat.empty;

    // decode gives the 7-bit byte; encode maps symbol to character: letters first, then digits
    always_comb begin
        if (mode == MODE_DECODE) begin
            out_char = {1'b0, grp_reg[GROUP_W-1 -: 7]};
        end else if (sym < 5'd26) begin
            out_char = 8'({3'b000, sym} + 8'd97);
        end else begin
            out_char = 8'({3'b000, sym} + 8'd22);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        idx_next  = idx_reg;
        end_next  = end_reg;
        if (pop) begin
            busy_next = 1'b1;
            grp_next  = head.bits;
            idx_next  = 3'd0;
            end_next  = head.msg_end;
        end else if (beat) begin
            if (out_last) begin
                busy_next = 1'b0;
            end else begin
                grp_next = (mode == MODE_DECODE) ? (grp_reg << 7) : (grp_reg << 5);
                idx_next = 3'(idx_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
        end_reg <= end_next;
    end

endmodule

`default_nettype wire

### design/base32_seven_bit_codec.sv
// ----------------------------------------------------------------------------
// base32_seven_bit_codec
// streaming codec between 7-bit bytes and 5-bit symbol characters
// ----------------------------------------------------------------------------
//  channel   dir   beat content
//  s_axis    in    tdata[7:0] in_char, tlast in_last
//  m_axis    out   tdata[7:0] out_char, tlast run_last, tuser message_end
//  apb       in    word 0 bit 0: mode (0 encode, 1 decode)
//
//  one input beat a cycle while the group queue has room
//  one output beat a cycle while m_tready is high; encode gives 7 beats per 5 inputs,
//  so its rate is set by the output serialiser; decode takes one a cycle
//  a closing beat's group is queued, then loaded to raise m_tvalid; no results before
//  reset clears the group, the queue and the serialiser at once
//  stalls on m_tready back up through the two-entry queue to s_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "base32_seven_bit_codec_assert.svh"

module base32_seven_bit_codec (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast,
    output logic             m_tuser,   // [0] message_end
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import b32s_pkg::*;

    logic        mode_reg, mode_next;
    logic        cfg_wr;
    logic        grp_push;
    group_t      push_grp;
    group_t      q_head;
    queue_stat_t q_stat;
    logic        q_pop;

    // register file: only the mode bit, any write to it drops the open group
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_comb begin
        mode_next = cfg_wr ? pwdata[0] : mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // front: packs items into a group, pushes it when full or at message end
    b32s_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode_reg),
        .clear    (cfg_wr),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_stat.full),
        .push     (grp_push),
        .push_grp (push_grp)
    );

    // two groups of slack so the front keeps taking beats during a run
    b32s_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (grp_push),
        .push_grp (push_grp),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // back: walks the group out one character a beat
    b32s_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .head      (q_head),
        .stat      (q_stat),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

    // a group is never pushed into a full queue
    `B32S_ASSERT(a_no_overflow, !(grp_push && q_stat.full), "group pushed into full queue")
    // a run carries on after a middle beat, with the same message_end flag
    `B32S_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast,
        m_tvalid && (m_tuser == $past(m_tuser)), "run broken or message_end changed")
    // the serialiser only takes a group from a non-empty queue
    `B32S_ASSERT(a_pop_nonempty, !(q_pop && q_stat.empty), "pop from empty queue")

endmodule

`default_nettype wire
